// ===== hw/rtl/dispatch_frame_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// dispatch_frame_parser_core_assert
// assertion macros for the frame parser rtl, sampled on clk and
// disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef DISPATCH_FRAME_PARSER_CORE_ASSERT_SVH
`define DISPATCH_FRAME_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define DFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dfp_pkg
// types and constants of the dispatch frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package dfp_pkg;

  // receive space ceiling and length digit limit
  localparam int SPACE_MAX         = 4096;
  localparam int SPACE_TOP         = (SPACE_MAX > 4096) ? 4096 : SPACE_MAX;
  localparam int LEN_DIGITS_MAX    = 8;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [12:0] SPACE_FLOOR = 13'd5;
  localparam logic [12:0] SPACE_RESET = 13'd4096;
  localparam logic [7:0]  DELIM_RESET = 8'd32;

  // saturating length accumulator
  localparam logic [26:0] LEN_CAP       = 27'h7FFFFFF;
  localparam logic [26:0] LEN_CAP_DIV10 = 27'(134217727 / 10);

  // prefix tags, first letter in the top byte
  localparam logic [23:0] TAG_ERR = 24'h455252;
  localparam logic [23:0] TAG_EXT = 24'h455854;
  localparam logic [23:0] TAG_END = 24'h454E44;
  localparam logic [23:0] TAG_CMD = 24'h434D44;
  localparam logic [23:0] TAG_MSG = 24'h4D5347;

  // configuration register indexes
  localparam logic REG_DELIMITER = 1'b0;
  localparam logic REG_MAX_SPACE = 1'b1;

  typedef enum logic [1:0] {
    FUNC_DATA   = 2'd0,
    FUNC_EOS    = 2'd1,
    FUNC_RDERR  = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_ERR  = 3'd0,
    KIND_EXT  = 3'd1,
    KIND_END  = 3'd2,
    KIND_CMD  = 3'd3,
    KIND_MSG  = 3'd4,
    KIND_FAIL = 3'd5,
    KIND_EOF  = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_CMD    = 3'd1,
    PH_LEN    = 3'd2,
    PH_BODY   = 3'd3,
    PH_TRAIL  = 3'd4
  } phase_t;

  // classified request handed from front to back
  typedef struct packed {
    func_t       func;
    logic [7:0]  data;
    logic        is_del;
    logic        is_digit;
    logic [3:0]  digit;
  } token_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dfp_front.sv =====
// ----------------------------------------------------------------------------
// dfp_front
// accepts input requests, classifies each byte and drops unused codes
// ----------------------------------------------------------------------------
`default_nettype none

module dfp_front (
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_func,
  input  wire logic [7:0]       in_byte,
  input  wire logic [7:0]       delimiter,
  input  wire logic             q_full,
  output logic                  push,
  output dfp_pkg::token_t       token
);

  logic [7:0] digit_off;

  // queue space decides acceptance
  assign in_ready = !q_full;

  // unused function code is taken and discarded
  assign push = in_valid && !q_full && (dfp_pkg::func_t'(in_func) != dfp_pkg::FUNC_UNUSED);

  // byte classification
  assign digit_off = in_byte - 8'h30;

  always_comb begin
    token.func     = dfp_pkg::func_t'(in_func);
    token.data     = in_byte;
    token.is_del   = (in_byte == delimiter);
    token.is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    token.digit    = digit_off[3:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dfp_queue.sv =====
// ----------------------------------------------------------------------------
// dfp_queue
// short register queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module dfp_queue #(
  parameter int DEPTH = dfp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire dfp_pkg::token_t  push_tok,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output dfp_pkg::token_t       head
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  dfp_pkg::token_t mem_r [DEPTH];
  logic [IW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dfp_back.sv =====
// ----------------------------------------------------------------------------
// dfp_back
// frame parsing state machine with registered result stage
// ----------------------------------------------------------------------------
`default_nettype none

module dfp_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [12:0]      max_space,
  input  wire logic             tok_valid,
  input  wire dfp_pkg::token_t  tok,
  output logic                  tok_pop,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output logic                  res_last,
  output dfp_pkg::kind_t        res_kind,
  output logic [7:0]            res_data,
  output logic [11:0]           res_len
);

  localparam logic [12:0] TOP = 13'(dfp_pkg::SPACE_TOP);

  dfp_pkg::phase_t phase_r, phase_nxt;
  logic [23:0] prefix_r, prefix_nxt;
  logic [12:0] cnt_r, cnt_nxt;
  logic [26:0] len_r, len_nxt;
  logic [3:0]  dig_r, dig_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic           out_last_r;
  dfp_pkg::kind_t out_kind_r;
  logic [7:0]     out_data_r;
  logic [11:0]    out_len_r;

  logic           emit;
  logic           emit_last;
  dfp_pkg::kind_t emit_kind;
  logic [7:0]     emit_data;
  logic [11:0]    emit_len;

  logic [12:0] lim, lim_m1, lim_m2, cnt_inc;
  logic [27:0] len_x10;
  logic [27:0] len_acc;

  // effective receive space limit
  always_comb begin
    lim = (max_space > TOP) ? TOP : max_space;
    if (lim < dfp_pkg::SPACE_FLOOR) begin
      lim = dfp_pkg::SPACE_FLOOR;
    end
  end
  assign lim_m1  = lim - 13'd1;
  assign lim_m2  = lim - 13'd2;
  assign cnt_inc = cnt_r + 13'd1;

  // decimal accumulate
  assign len_x10 = ({1'b0, len_r} << 3) + ({1'b0, len_r} << 1);
  assign len_acc = len_x10 + 28'(tok.digit);

  // take a request when the result stage can hold what it makes
  assign tok_pop = tok_valid && (!out_valid_r || res_ready);

  // parser next state and result
  always_comb begin
    phase_nxt  = phase_r;
    prefix_nxt = prefix_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    dig_nxt    = dig_r;
    emit       = 1'b0;
    emit_last  = 1'b1;
    emit_kind  = dfp_pkg::KIND_FAIL;
    emit_data  = 8'd0;
    emit_len   = 12'd0;

    if (tok_pop) begin
      priority if (tok.func == dfp_pkg::FUNC_EOS) begin
        emit      = 1'b1;
        emit_kind = dfp_pkg::KIND_EOF;
      end else if (tok.func == dfp_pkg::FUNC_RDERR) begin
        emit      = 1'b1;
        emit_kind = dfp_pkg::KIND_FAIL;
      end else if (tok.func == dfp_pkg::FUNC_DATA) begin
        unique case (phase_r)
          dfp_pkg::PH_PREFIX: begin
            priority if (cnt_r >= 13'd4) begin
              emit = 1'b1;
            end else if (tok.is_del) begin
              priority if (cnt_r != 13'd3) begin
                emit = 1'b1;
              end else if (prefix_r == dfp_pkg::TAG_ERR) begin
                emit      = 1'b1;
                emit_kind = dfp_pkg::KIND_ERR;
              end else if (prefix_r == dfp_pkg::TAG_EXT) begin
                emit      = 1'b1;
                emit_kind = dfp_pkg::KIND_EXT;
              end else if (prefix_r == dfp_pkg::TAG_END) begin
                emit      = 1'b1;
                emit_kind = dfp_pkg::KIND_END;
              end else if (prefix_r == dfp_pkg::TAG_CMD) begin
                phase_nxt  = dfp_pkg::PH_CMD;
                prefix_nxt = '0;
                cnt_nxt    = '0;
              end else if (prefix_r == dfp_pkg::TAG_MSG) begin
                phase_nxt  = dfp_pkg::PH_LEN;
                prefix_nxt = '0;
                cnt_nxt    = '0;
              end else begin
                emit = 1'b1;
              end
            end else begin
              prefix_nxt = {prefix_r[15:0], tok.data};
              cnt_nxt    = cnt_inc;
            end
          end
          dfp_pkg::PH_CMD: begin
            priority if (cnt_r >= lim_m1) begin
              emit      = 1'b1;
              emit_kind = dfp_pkg::KIND_CMD;
              emit_len  = 12'(cnt_r - 13'd1);
            end else if (tok.is_del) begin
              emit = 1'b1;
              if (cnt_r != '0) begin
                emit_kind = dfp_pkg::KIND_CMD;
                emit_len  = cnt_r[11:0];
              end
            end else begin
              cnt_nxt = cnt_inc;
              if (cnt_inc <= lim_m2) begin
                emit      = 1'b1;
                emit_last = 1'b0;
                emit_kind = dfp_pkg::KIND_CMD;
                emit_data = tok.data;
              end
            end
          end
          dfp_pkg::PH_LEN: begin
            priority if (tok.is_del) begin
              priority if (dig_r == '0) begin
                emit = 1'b1;
              end else if (len_r > 27'(lim_m1)) begin
                emit = 1'b1;
              end else begin
                cnt_nxt   = '0;
                phase_nxt = (len_r == '0) ? dfp_pkg::PH_TRAIL : dfp_pkg::PH_BODY;
              end
            end else if (!tok.is_digit) begin
              emit = 1'b1;
            end else if (dig_r >= 4'(dfp_pkg::LEN_DIGITS_MAX)) begin
              emit = 1'b1;
            end else begin
              dig_nxt = dig_r + 4'd1;
              if (len_r > dfp_pkg::LEN_CAP_DIV10) begin
                len_nxt = dfp_pkg::LEN_CAP;
              end else if (len_acc > {1'b0, dfp_pkg::LEN_CAP}) begin
                len_nxt = dfp_pkg::LEN_CAP;
              end else begin
                len_nxt = len_acc[26:0];
              end
            end
          end
          dfp_pkg::PH_BODY: begin
            cnt_nxt = cnt_inc;
            if (27'(cnt_inc) >= len_r) begin
              phase_nxt = dfp_pkg::PH_TRAIL;
            end
            emit      = 1'b1;
            emit_last = 1'b0;
            emit_kind = dfp_pkg::KIND_MSG;
            emit_data = tok.data;
          end
          dfp_pkg::PH_TRAIL: begin
            emit = 1'b1;
            if (tok.is_del) begin
              emit_kind = dfp_pkg::KIND_MSG;
              emit_len  = len_r[11:0];
            end
          end
          default: begin
            phase_nxt  = dfp_pkg::PH_PREFIX;
            prefix_nxt = '0;
            cnt_nxt    = '0;
            len_nxt    = '0;
            dig_nxt    = '0;
          end
        endcase
      end else begin
        emit = 1'b0;
      end

      // a frame-done result restarts at the prefix
      if (emit && emit_last) begin
        phase_nxt  = dfp_pkg::PH_PREFIX;
        prefix_nxt = '0;
        cnt_nxt    = '0;
        len_nxt    = '0;
        dig_nxt    = '0;
      end
    end
  end

  // result stage valid
  always_comb begin
    out_valid_nxt = out_valid_r && !res_ready;
    if (tok_pop) begin
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dfp_pkg::PH_PREFIX;
      prefix_r    <= '0;
      cnt_r       <= '0;
      len_r       <= '0;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      prefix_r    <= prefix_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      dig_r       <= dig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (tok_pop && emit) begin
      out_last_r <= emit_last;
      out_kind_r <= emit_kind;
      out_data_r <= emit_data;
      out_len_r  <= emit_len;
    end
  end

  assign res_valid = out_valid_r;
  assign res_last  = out_last_r;
  assign res_kind  = out_kind_r;
  assign res_data  = out_data_r;
  assign res_len   = out_len_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dispatch_frame_parser_core.sv =====
// path: an input request reaches result valid through the front-to-back
//   queue register and then the result register of the parser
// throughput: one input request per cycle while the queue is not full, each giving zero or one result
// reset: synchronous active-low rst_n empties the queue and result stage, restarts
//   at prefix collection and loads delimiter 32 and max_space 4096
`default_nettype none
`include "dispatch_frame_parser_core_assert.svh"

// ----------------------------------------------------------------------------
// dispatch_frame_parser_core
// deframes a text frame byte stream into payload bytes and frame-done results
// ----------------------------------------------------------------------------
module dispatch_frame_parser_core #(
  parameter int QUEUE_DEPTH = dfp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] data_out, [19:8] content_length, [23:20] zero
  output logic [2:0]       out_tuser,  // [2:0] kind
  output logic             out_tlast,  // event_res
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data
);

  logic [7:0]      delim_r, delim_nxt;
  logic [12:0]     space_r, space_nxt;
  logic            q_full, q_push, q_pop, q_not_empty;
  dfp_pkg::token_t front_tok, q_head;
  dfp_pkg::kind_t  res_kind;
  logic [7:0]      res_data;
  logic [11:0]     res_len;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    delim_nxt = delim_r;
    space_nxt = space_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        dfp_pkg::REG_DELIMITER: delim_nxt = cfg_data[7:0];
        dfp_pkg::REG_MAX_SPACE: space_nxt = cfg_data;
        default:                delim_nxt = delim_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= dfp_pkg::DELIM_RESET;
      space_r <= dfp_pkg::SPACE_RESET;
    end else begin
      delim_r <= delim_nxt;
      space_r <= space_nxt;
    end
  end

  // front: accept and classify
  dfp_front u_front (
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_byte   (in_tdata),
    .delimiter (delim_r),
    .q_full    (q_full),
    .push      (q_push),
    .token     (front_tok)
  );

  // queue between front and back
  dfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (front_tok),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: parse and register results
  dfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_space (space_r),
    .tok_valid (q_not_empty),
    .tok       (q_head),
    .tok_pop   (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_last  (out_tlast),
    .res_kind  (res_kind),
    .res_data  (res_data),
    .res_len   (res_len)
  );

  assign out_tdata = {4'd0, res_len, res_data};
  assign out_tuser = res_kind;

  // checks
  `DFP_ASSERT_IMP(a_pop_needs_entry, q_pop, q_not_empty, "pop from empty queue")
  `DFP_ASSERT_IMP(a_payload_kind,
    out_tvalid && !out_tlast,
    (out_tuser == dfp_pkg::KIND_CMD || out_tuser == dfp_pkg::KIND_MSG) && out_tdata[19:8] == 12'd0,
    "payload result with bad kind or length")
  `DFP_ASSERT_IMP(a_done_fields,
    out_tvalid && out_tlast && out_tuser != dfp_pkg::KIND_CMD && out_tuser != dfp_pkg::KIND_MSG,
    out_tdata[19:0] == 20'd0,
    "frame-done result carries nonzero fields")
  `DFP_ASSERT_NXT(a_stall_holds_queue, q_full && !q_pop, q_full, "queue lost an entry while stalled")

endmodule

`default_nettype wire

// ===== test/dispatch_frame_parser_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dispatch_frame_parser_core_test
// drives text frames byte by byte into the frame parser, runs a model of the
// deframing rules beside it and checks every payload and frame-done result in
// order; covers each prefix, malformed fields, stream ends, several delimiter
// and receive space settings, random idling on both sides and back-pressure
// ----------------------------------------------------------------------------
module dispatch_frame_parser_core_test;

  // one result of the parser, laid out as {tlast, tuser, byte, length}
  typedef struct packed {
    logic            frame_done;
    dfp_pkg::kind_t  kind;
    logic [7:0]      data;
    logic [11:0]     byte_total;
  } parser_event_t;

  // deframing model and the results it still waits for
  class frame_checker;
    logic [7:0]      delim;
    logic [12:0]     space_reg;
    dfp_pkg::phase_t phase;
    logic [23:0]     tag;
    logic [12:0]     taken;
    logic [26:0]     msg_len;
    logic [3:0]      digits;
    parser_event_t   pending_events[$];
    int              mismatches;

    function new();
      delim = dfp_pkg::DELIM_RESET;
      space_reg = dfp_pkg::SPACE_RESET;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      phase = dfp_pkg::PH_PREFIX;
      tag = '0;
      taken = '0;
      msg_len = '0;
      digits = '0;
    endfunction

    function void set_register(logic idx, logic [12:0] value);
      if (idx == dfp_pkg::REG_DELIMITER) begin
        delim = value[7:0];
      end else begin
        space_reg = value;
      end
    endfunction

    function void close_frame(dfp_pkg::kind_t k, logic [12:0] n);
      parser_event_t ev;
      restart();
      ev.frame_done = 1'b1;
      ev.kind = k;
      ev.data = '0;
      ev.byte_total = n[11:0];
      pending_events.push_back(ev);
    endfunction

    function void payload(dfp_pkg::kind_t k, logic [7:0] b);
      parser_event_t ev;
      ev.frame_done = 1'b0;
      ev.kind = k;
      ev.data = b;
      ev.byte_total = '0;
      pending_events.push_back(ev);
    endfunction

    // advance the parser by one accepted request
    function void note_request(logic [1:0] f, logic [7:0] b);
      logic [12:0] lim;
      logic        is_delim;
      int unsigned acc;
      lim = (space_reg > 13'd4096) ? 13'd4096 : space_reg;
      if (lim < dfp_pkg::SPACE_FLOOR) lim = dfp_pkg::SPACE_FLOOR;
      is_delim = (b == delim);
      if (f == dfp_pkg::FUNC_EOS) begin
        close_frame(dfp_pkg::KIND_EOF, '0);
      end else if (f == dfp_pkg::FUNC_RDERR) begin
        close_frame(dfp_pkg::KIND_FAIL, '0);
      end else if (f == dfp_pkg::FUNC_DATA) begin
        case (phase)
          dfp_pkg::PH_PREFIX: begin
            // four letters without a delimiter is already too long
            if (taken >= 13'd4) begin
              close_frame(dfp_pkg::KIND_FAIL, '0);
            end else if (is_delim) begin
              if (taken != 13'd3) close_frame(dfp_pkg::KIND_FAIL, '0);
              else if (tag == dfp_pkg::TAG_ERR) close_frame(dfp_pkg::KIND_ERR, '0);
              else if (tag == dfp_pkg::TAG_EXT) close_frame(dfp_pkg::KIND_EXT, '0);
              else if (tag == dfp_pkg::TAG_END) close_frame(dfp_pkg::KIND_END, '0);
              else if (tag == dfp_pkg::TAG_CMD) begin
                restart();
                phase = dfp_pkg::PH_CMD;
              end else if (tag == dfp_pkg::TAG_MSG) begin
                restart();
                phase = dfp_pkg::PH_LEN;
              end else close_frame(dfp_pkg::KIND_FAIL, '0);
            end else begin
              tag = {tag[15:0], b};
              taken = taken + 13'd1;
            end
          end
          dfp_pkg::PH_CMD: begin
            // full receive space: next byte ends the command, last one dropped
            if (taken >= lim - 13'd1) begin
              close_frame(dfp_pkg::KIND_CMD, taken - 13'd1);
            end else if (is_delim) begin
              if (taken == '0) close_frame(dfp_pkg::KIND_FAIL, '0);
              else close_frame(dfp_pkg::KIND_CMD, taken);
            end else begin
              taken = taken + 13'd1;
              if (taken <= lim - 13'd2) payload(dfp_pkg::KIND_CMD, b);
            end
          end
          dfp_pkg::PH_LEN: begin
            if (is_delim) begin
              if (digits == '0) close_frame(dfp_pkg::KIND_FAIL, '0);
              else if (msg_len > {14'd0, lim - 13'd1}) close_frame(dfp_pkg::KIND_FAIL, '0);
              else begin
                taken = '0;
                phase = (msg_len == '0) ? dfp_pkg::PH_TRAIL : dfp_pkg::PH_BODY;
              end
            end else if (b < "0" || b > "9") begin
              close_frame(dfp_pkg::KIND_FAIL, '0);
            end else if (digits >= dfp_pkg::LEN_DIGITS_MAX) begin
              close_frame(dfp_pkg::KIND_FAIL, '0);
            end else begin
              digits = digits + 4'd1;
              if (msg_len > dfp_pkg::LEN_CAP_DIV10) begin
                msg_len = dfp_pkg::LEN_CAP;
              end else begin
                acc = msg_len * 10 + (b - "0");
                msg_len = (acc > dfp_pkg::LEN_CAP) ? dfp_pkg::LEN_CAP : acc[26:0];
              end
            end
          end
          dfp_pkg::PH_BODY: begin
            taken = taken + 13'd1;
            if ({14'd0, taken} >= msg_len) phase = dfp_pkg::PH_TRAIL;
            payload(dfp_pkg::KIND_MSG, b);
          end
          dfp_pkg::PH_TRAIL: begin
            if (is_delim) close_frame(dfp_pkg::KIND_MSG, msg_len[12:0]);
            else close_frame(dfp_pkg::KIND_FAIL, '0);
          end
          default: restart();
        endcase
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", msg);
    endtask

    // compare one accepted result with the oldest one predicted
    task check_result(parser_event_t got);
      parser_event_t want;
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected result last=%b kind=%0d data=%h len=%0d",
                         got.frame_done, got.kind, got.data, got.byte_total));
      end else begin
        want = pending_events.pop_front();
        if (got.frame_done !== want.frame_done || got.kind !== want.kind ||
            got.data !== want.data || got.byte_total !== want.byte_total) begin
          report($sformatf("got last=%b kind=%0d data=%h len=%0d, want %b %0d %h %0d",
                           got.frame_done, got.kind, got.data, got.byte_total,
                           want.frame_done, want.kind, want.data, want.byte_total));
        end
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [12:0] cfg_data;

  frame_checker  results = new();
  parser_event_t seen;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            stall_cycles;
  int            items_sent;
  logic [7:0]    cur_delim;
  logic [12:0]   cur_space;

  dispatch_frame_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver: random idling, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (stall_cycles != 0) begin
      out_tready <= 1'b0;
      stall_cycles = stall_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watch all three channels; results first, so a same-edge request queues behind
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen = {out_tlast, out_tuser, out_tdata[7:0], out_tdata[19:8]};
        results.check_result(seen);
      end
      if (in_tvalid && in_tready) results.note_request(in_tuser, in_tdata);
      if (cfg_valid && cfg_ready) results.set_register(cfg_index, cfg_data);
    end
  end

  // receive space as the parser clamps it
  function automatic int cur_limit();
    int lim;
    lim = (cur_space > 13'd4096) ? 4096 : cur_space;
    if (lim < 5) lim = 5;
    return lim;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == cur_delim) b = 8'($urandom_range(255));
    return b;
  endfunction

  // offer one request; starts and ends at a falling edge
  task automatic send_request(input logic [1:0] f, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (f != dfp_pkg::FUNC_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_data(input logic [7:0] b);
    send_request(dfp_pkg::FUNC_DATA, b);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_data(s[i]);
  endtask

  // stop offering and let every predicted result drain out
  task automatic wait_for_results();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (results.pending_events.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == dfp_pkg::REG_DELIMITER) cur_delim = value[7:0];
    else cur_space = value;
  endtask

  // cfg_valid drops between the two writes
  task automatic retune(input logic [7:0] delim, input logic [12:0] space);
    wait_for_results();
    write_register(dfp_pkg::REG_DELIMITER, {5'd0, delim});
    @(negedge clk);
    write_register(dfp_pkg::REG_MAX_SPACE, space);
  endtask

  // one random frame, well formed most of the time
  task automatic send_random_frame();
    int         choice;
    int         n;
    int         lim;
    logic [7:0] letter;
    choice = $urandom_range(99);
    lim = cur_limit();
    if (choice < 10) begin
      // frames with no body
      case ($urandom_range(2))
        0: send_string("ERR");
        1: send_string("EXT");
        default: send_string("END");
      endcase
      send_data(cur_delim);
    end else if (choice < 35) begin
      // command with ordinary text
      send_string("CMD");
      send_data(cur_delim);
      repeat ($urandom_range(1, 10)) send_data(text_byte());
      send_data(cur_delim);
    end else if (choice < 65) begin
      // message, now and then a long body or a bad trailer
      if ($urandom_range(7) == 0) begin
        n = $urandom_range((lim <= 100) ? lim - 1 : 40);
      end else begin
        n = $urandom_range((lim - 1 < 6) ? lim - 1 : 6);
      end
      send_string("MSG");
      send_data(cur_delim);
      send_string($sformatf("%0d", n));
      send_data(cur_delim);
      repeat (n) send_data(8'($urandom_range(255)));
      if ($urandom_range(9) == 0) send_data(text_byte());
      else send_data(cur_delim);
    end else if (choice < 75) begin
      // loose bytes with delimiters among them
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(3) == 0) send_data(cur_delim);
        else send_data(text_byte());
      end
    end else if (choice < 80) begin
      // stream cut short by end of stream or read error
      if ($urandom_range(1) == 1) begin
        send_string("CMD");
        send_data(cur_delim);
      end
      send_data(text_byte());
      if ($urandom_range(1) == 1) send_request(dfp_pkg::FUNC_EOS, text_byte());
      else send_request(dfp_pkg::FUNC_RDERR, text_byte());
    end else if (choice < 85) begin
      // ignored request inside a prefix
      send_string("ER");
      send_request(dfp_pkg::FUNC_UNUSED, text_byte());
      send_string("R");
      send_data(cur_delim);
    end else if (choice < 90) begin
      // malformed length field
      send_string("MSG");
      send_data(cur_delim);
      case ($urandom_range(3))
        0: send_data(cur_delim);
        1: send_string("7q");
        2: send_string("123456789");
        default: begin
          send_string($sformatf("%0d", lim + $urandom_range(3)));
          send_data(cur_delim);
        end
      endcase
    end else if (choice < 95) begin
      // prefix of the wrong size or letters
      repeat ($urandom_range(5)) begin
        letter = 8'($urandom_range(25));
        send_data("A" + letter);
      end
      send_data(cur_delim);
    end else begin
      // empty command, or one that runs past the receive space
      send_string("CMD");
      send_data(cur_delim);
      if (lim <= 100 && $urandom_range(1) == 1) repeat (lim) send_data(text_byte());
      else send_data(cur_delim);
    end
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) send_random_frame();
  endtask

  // time limit
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = dfp_pkg::FUNC_DATA;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = dfp_pkg::REG_DELIMITER;
    cfg_data = '0;
    stall_cycles = 0;
    items_sent = 0;
    cur_delim = dfp_pkg::DELIM_RESET;
    cur_space = dfp_pkg::SPACE_RESET;
    send_idle_pct = 37;
    recv_idle_pct = 83;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // each frame kind and each way to break one, reset settings
    send_string("ERR ");
    send_string("EXT ");
    send_string("END ");
    send_string("CMD hello ");
    send_string("MSG 5 ab cd ");
    send_string("MSG 0  ");
    send_string("MSG 2 ");
    send_data(8'h00);
    send_data(8'hFF);
    send_data(" ");
    send_string("CM");
    send_request(dfp_pkg::FUNC_EOS, 8'hFF);
    send_string("MSG 12");
    send_request(dfp_pkg::FUNC_RDERR, 8'h00);
    send_string("EN");
    send_request(dfp_pkg::FUNC_UNUSED, " ");
    send_string("D ");
    send_string(" ");
    send_string("AB ");
    send_string("ABCDE");
    send_string("XYZ ");
    send_string("CMD  ");
    send_string("MSG  ");
    send_string("MSG 1a");
    send_string("MSG 123456789");
    send_string("MSG 4096 ");
    send_string("MSG 2 abX");
    send_string("MSG 4095 ");
    send_request(dfp_pkg::FUNC_EOS, 8'h00);
    // smallest receive space: command cut short, length limit
    retune(" ", 13'd5);
    send_string("CMD abcde");
    send_string("MSG 4 wxyz ");
    send_string("MSG 5 ");
    // delimiter that is also a digit
    retune("5", 13'd5);
    send_string("MSG515x5");

    // random frames over several settings, long hold-off at the start
    retune(",", 13'd12);
    stall_cycles = 80;
    run_random(45);
    retune(8'h00, 13'd5);
    run_random(45);
    send_idle_pct = 83;
    recv_idle_pct = 37;
    retune(8'hFF, 13'd4096);
    run_random(45);
    retune("5", 13'd30);
    run_random(45);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    retune("Z", 13'd9);
    run_random(45);
    retune(" ", 13'd100);
    run_random(45);

    wait_for_results();
    if (results.pending_events.size() != 0) begin
      results.report($sformatf("%0d results never arrived", results.pending_events.size()));
    end
    if (results.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
